// ===== src/optb_pkg.sv =====
`timescale 1ns / 1ps

package optb_pkg;

    // Default bank size and fixed field widths
    localparam int TIMERS_DEF    = 8;
    localparam int MS_W          = 32;
    localparam int STEP_W        = 10;
    localparam int HITS_W        = 10;
    localparam int IN_SLOT_W     = 3;

    localparam logic [STEP_W-1:0] TICK_STEP_RST = 10'd10;
    localparam logic [HITS_W-1:0] EXPIRY_MAX    = 10'd1000;

    // Restoring divide of a 33-bit count, one quotient bit per cycle
    localparam int CNT_W     = MS_W + 1;
    localparam int DIV_STEPS = CNT_W;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_SET   = 2'd1,
        KIND_START = 2'd2,
        KIND_STOP  = 2'd3
    } kind_t;

    // One timer entry as held in the state memory
    typedef struct packed {
        logic [MS_W-1:0] reload;
        logic [MS_W-1:0] period;
        logic [MS_W-1:0] elapsed;
    } entry_t;

endpackage

// ===== src/oneshot_periodic_timer_bank.sv =====
`timescale 1ns / 1ps

// Channel    Dir  Handshake          Payload (lowest bit up)
// s_*        in   s_tvalid/s_tready  tuser: kind[1:0]
//                                    tdata: timer_slot[2:0] start_now[3]
//                                           initial_ms[35:4] reload_ms[67:36]
// m_*        out  m_tvalid/m_tready  tdata: slot_index[2:0] expiry_count[12:3]
//                                           still_running[13]; tlast: last
// cfg_*      in   cfg_we             cfg_wdata: tick_step[9:0]
//
// Set, start and stop requests are applied when accepted. A tick walks
// every slot in turn: read, advance, compare, then for a periodic expiry
// a restoring divide, then write-back and report. Reset clears the
// running flags and entry valid bits at once; an entry not yet written
// reads as zero. A stalled report holds the walk at the next slot; after
// the final report the block takes a new request at once.

module oneshot_periodic_timer_bank #(
    parameter int TIMERS = optb_pkg::TIMERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // timer_slot, start_now, initial_ms, reload_ms, pad
    input  logic [1:0]  s_tuser,   // kind
    // report stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // slot_index, expiry_count, still_running, pad
    output logic        m_tlast,   // last
    // tick_step register
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata
);

    localparam int SLOT_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int IDX_W  = (SLOT_W > optb_pkg::IN_SLOT_W) ? SLOT_W : optb_pkg::IN_SLOT_W;
    localparam int MS_W   = optb_pkg::MS_W;
    localparam int CNT_W  = optb_pkg::CNT_W;
    localparam int DCNT_W = $clog2(optb_pkg::DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,   // memory data arrives, count advanced
        S_CALC,   // compare with period, first expiry
        S_DIV,    // remaining expiries and new count
        S_FIN,    // saturate expiry count
        S_EMIT    // write back and report
    } state_t;

    state_t state_reg;

    // Request fields
    optb_pkg::kind_t         in_kind;
    logic [2:0]              in_slot;
    logic                    in_start_now;
    logic [MS_W-1:0]         in_initial;
    logic [MS_W-1:0]         in_reload;
    logic [IDX_W-1:0]        in_slot_ext;
    logic [SLOT_W-1:0]       in_idx;
    logic                    in_range;
    logic                    in_acc;

    assign in_kind      = optb_pkg::kind_t'(s_tuser);
    assign in_slot      = s_tdata[2:0];
    assign in_start_now = s_tdata[3];
    assign in_initial   = s_tdata[35:4];
    assign in_reload    = s_tdata[67:36];
    assign in_slot_ext  = IDX_W'(in_slot);
    assign in_idx       = in_slot_ext[SLOT_W-1:0];
    assign in_range     = 32'(in_slot) < TIMERS;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // Control and working registers
    logic [optb_pkg::STEP_W-1:0] tick_step_reg;
    logic [TIMERS-1:0]           run_flag_reg;
    logic [TIMERS-1:0]           ent_valid_reg;
    logic [SLOT_W-1:0]           slot_reg;
    logic                        run_reg;
    logic [MS_W-1:0]             el_reg;
    logic [MS_W-1:0]             per_reg;
    logic [MS_W-1:0]             rel_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [MS_W-1:0]             rem_reg;
    logic [CNT_W-1:0]            quo_reg;
    logic [DCNT_W-1:0]           div_cnt_reg;
    logic [optb_pkg::HITS_W-1:0] hits_reg;

    // Report register
    logic                        m_tvalid_reg;
    logic [2:0]                  out_slot_reg;
    logic [optb_pkg::HITS_W-1:0] out_hits_reg;
    logic                        out_run_reg;
    logic                        out_last_reg;

    // State memory
    optb_pkg::entry_t mem [TIMERS];
    optb_pkg::entry_t rd_data_reg;
    logic             mem_re;
    logic [SLOT_W-1:0] mem_raddr;
    logic             mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    optb_pkg::entry_t mem_wdata;

    logic             last_slot;
    logic             emit_go;
    logic [IDX_W-1:0] slot_ext;

    assign last_slot = (slot_reg == SLOT_W'(TIMERS - 1));
    assign emit_go   = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);
    assign slot_ext  = IDX_W'(slot_reg);

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = '{reload: rel_reg, period: per_reg, elapsed: el_reg};
        if (in_acc && in_kind == optb_pkg::KIND_TICK)
        begin
            mem_re = 1'b1;
        end
        else if (in_acc && in_kind == optb_pkg::KIND_SET && in_range)
        begin
            mem_we    = 1'b1;
            mem_waddr = in_idx;
            mem_wdata = '{reload: in_reload, period: in_initial, elapsed: '0};
        end
        if (emit_go)
        begin
            mem_we = 1'b1;
            if (!last_slot)
            begin
                mem_re    = 1'b1;
                mem_raddr = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Entry as seen by the walk: never-written entries read as zero
    optb_pkg::entry_t ent;
    logic [CNT_W-1:0] step_add;
    assign ent      = ent_valid_reg[slot_reg] ? rd_data_reg : '0;
    assign step_add = (ent.period != '0) ? CNT_W'(tick_step_reg) : '0;

    // First expiry
    logic [CNT_W-1:0] diff;
    logic             below;
    assign below = cnt_reg < {1'b0, per_reg};
    assign diff  = cnt_reg - {1'b0, per_reg};

    // One restoring divide step
    logic [CNT_W-1:0] trial;
    logic             trial_ge;
    logic [MS_W-1:0]  rem_next;
    assign trial    = {rem_reg, quo_reg[CNT_W-1]};
    assign trial_ge = trial >= {1'b0, rel_reg};
    assign rem_next = trial_ge ? MS_W'(trial - {1'b0, rel_reg}) : trial[MS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_step_reg <= optb_pkg::TICK_STEP_RST;
            run_flag_reg  <= '0;
            ent_valid_reg <= '0;
            slot_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tick_step_reg <= cfg_wdata;
            end

            if (m_tvalid_reg && m_tready && !emit_go)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        unique case (in_kind)
                            optb_pkg::KIND_TICK:
                            begin
                                slot_reg  <= '0;
                                state_reg <= S_LOAD;
                            end
                            optb_pkg::KIND_SET:
                            begin
                                if (in_range)
                                begin
                                    run_flag_reg[in_idx]  <= in_start_now;
                                    ent_valid_reg[in_idx] <= 1'b1;
                                end
                            end
                            optb_pkg::KIND_START:
                            begin
                                if (in_range)
                                begin
                                    run_flag_reg[in_idx] <= 1'b1;
                                end
                            end
                            optb_pkg::KIND_STOP:
                            begin
                                if (in_range)
                                begin
                                    run_flag_reg[in_idx] <= 1'b0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_LOAD:
                begin
                    run_reg   <= run_flag_reg[slot_reg];
                    el_reg    <= ent.elapsed;
                    per_reg   <= ent.period;
                    rel_reg   <= ent.reload;
                    cnt_reg   <= {1'b0, ent.elapsed} + step_add;
                    state_reg <= S_CALC;
                end

                S_CALC:
                begin
                    if (!run_reg || below)
                    begin
                        if (run_reg)
                        begin
                            el_reg <= cnt_reg[MS_W-1:0];
                        end
                        hits_reg  <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (rel_reg == '0)
                    begin
                        // one-shot: stop and clear
                        run_reg   <= 1'b0;
                        el_reg    <= '0;
                        hits_reg  <= optb_pkg::HITS_W'(1);
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        per_reg     <= rel_reg;
                        quo_reg     <= diff;
                        rem_reg     <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    rem_reg     <= rem_next;
                    quo_reg     <= {quo_reg[CNT_W-2:0], trial_ge};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DCNT_W'(optb_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= S_FIN;
                    end
                end

                S_FIN:
                begin
                    el_reg <= rem_reg;
                    if (quo_reg >= CNT_W'(optb_pkg::EXPIRY_MAX))
                    begin
                        hits_reg <= optb_pkg::EXPIRY_MAX;
                    end
                    else
                    begin
                        hits_reg <= optb_pkg::HITS_W'(quo_reg + 1'b1);
                    end
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        run_flag_reg[slot_reg]  <= run_reg;
                        ent_valid_reg[slot_reg] <= 1'b1;
                        m_tvalid_reg <= 1'b1;
                        out_slot_reg <= slot_ext[2:0];
                        out_hits_reg <= hits_reg;
                        out_run_reg  <= run_reg;
                        out_last_reg <= last_slot;
                        if (last_slot)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            slot_reg  <= slot_reg + 1'b1;
                            state_reg <= S_LOAD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_run_reg, out_hits_reg, out_slot_reg};
    assign m_tlast  = out_last_reg;

endmodule
